FILE: sv/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page frame manager.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

  // Number of page frames and width of a stored page identifier.
  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;

  // Derived widths.
  localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W   = $clog2(FRAMES + 1);
  localparam int CFG_W   = 4;
  localparam int FAULT_W = 32;
  localparam int STAT_W  = 2;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CFG_W-1:0]     cfg_t;
  typedef logic [FAULT_W-1:0]   fault_t;
  typedef logic [STAT_W-1:0]    stat_t;

  // Result status codes.
  localparam stat_t ST_HIT   = 2'd0;
  localparam stat_t ST_FREE  = 2'd1;
  localparam stat_t ST_EVICT = 2'd2;
  localparam stat_t ST_ERR   = 2'd3;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // capture a new reference and restart the frame scan
    logic step;    // examine one frame
    logic commit;  // apply the update and load the result register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_last;  // the frame under examination is the last one
  } sts_t;

endpackage

`default_nettype wire

FILE: sv/lru_page_replacement.sv
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page frame manager with a saturating fault count.
// ----------------------------------------------------------------------------
// Each input transaction is one page reference and produces exactly one
// result transaction. A reference that finds its page resident is a hit and
// makes that page the most recent. A miss loads the page into the
// lowest-numbered free frame while fewer pages are resident than
// cfg_wr_data last allowed; otherwise it evicts the least recently used page
// and reports it. Misses bump a fault count that holds at its maximum. With
// zero frames configured the result is the error status and nothing changes.
// A setting above the frame count acts as the full frame count; lowering it
// never drops pages at once, later misses just replace instead of fill.
// A reference is accepted, then the frame scan examines one frame per
// cycle, and then a commit applies the update; no new reference is taken
// before that commit. The result register is loaded at commit and a new
// reference is accepted in that same cycle, so a waiting result only
// delays the commit of the next reference, not its scan.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire lrupr_pkg::cfg_t   cfg_wr_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire lrupr_pkg::page_t  in_page_number,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output lrupr_pkg::stat_t       out_status,
  output lrupr_pkg::page_t       out_evicted_page,
  output lrupr_pkg::fault_t      out_fault_total,
  output lrupr_pkg::cnt_t        out_resident_count
);
  import lrupr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // The sequencer owns the handshakes and the output valid flag.
  lrupr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the frame table, the configuration and the result.
  lrupr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_page_number     (in_page_number),
    .out_status         (out_status),
    .out_evicted_page   (out_evicted_page),
    .out_fault_total    (out_fault_total),
    .out_resident_count (out_resident_count)
  );

  // The resident count can never exceed the number of physical frames.
  a_resident_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_resident_count) <= FRAMES))
    else $error("resident count above frame count");

  // Only an eviction reports a page; every other status reports zero.
  a_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_EVICT)) |-> (out_evicted_page == '0))
    else $error("evicted page reported without eviction");

  // An eviction or fill is a fault, so the fault total cannot be zero.
  a_fault_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ((out_status == ST_EVICT) || (out_status == ST_FREE)))
      |-> (out_fault_total != '0))
    else $error("fault result with zero fault total");

  // After accepting a reference the block is busy scanning.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second reference accepted during scan");

endmodule

`default_nettype wire

FILE: sv/lrupr_ctrl.sv
// ----------------------------------------------------------------------------
// lrupr_ctrl
// Sequencer for the LRU page frame manager: accept, scan frames, commit.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire lrupr_pkg::sts_t  sts,
  output lrupr_pkg::cmd_t       cmd
);
  import lrupr_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;
  logic       accept;

  // The result register can take a new transaction when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // A new reference may enter while idle or in the same cycle as a commit.
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_COMMIT) && out_free));
  assign accept   = in_valid && !in_stall;

  assign cmd.load   = accept;
  assign cmd.step   = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && out_free;

  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_last) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (accept)        state_nxt = S_SCAN;
        else if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit)      out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lrupr_dp.sv
// ----------------------------------------------------------------------------
// lrupr_dp
// Frame table, recency ranks, frame scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lrupr_pkg::cmd_t   cmd,
  output lrupr_pkg::sts_t        sts,
  input  wire logic              cfg_wr_en,
  input  wire lrupr_pkg::cfg_t   cfg_wr_data,
  input  wire lrupr_pkg::page_t  in_page_number,
  output lrupr_pkg::stat_t       out_status,
  output lrupr_pkg::page_t       out_evicted_page,
  output lrupr_pkg::fault_t      out_fault_total,
  output lrupr_pkg::cnt_t        out_resident_count
);
  import lrupr_pkg::*;

  // Frame table.
  logic [FRAMES-1:0] frame_valid_r;
  page_t             frame_page_r [FRAMES];
  idx_t              frame_rank_r [FRAMES];
  idx_t              rank_nxt     [FRAMES];

  cfg_t   cfg_r;
  fault_t fault_r, fault_nxt;
  cnt_t   resident_r, resident_nxt;
  page_t  page_r;

  // Scan trackers.
  idx_t  idx_r;
  logic  hit_found_r, free_found_r, vic_found_r;
  idx_t  hit_idx_r, hit_rank_r, free_idx_r, vic_idx_r, vic_rank_r;
  page_t vic_page_r;

  // Scan read port.
  logic  cur_valid;
  page_t cur_page;
  idx_t  cur_rank;

  // Commit decision.
  cnt_t  limit;
  stat_t status;
  idx_t  slot;
  cnt_t  promo_lim;
  logic  do_promote, do_load, do_fill;
  page_t evicted;

  stat_t  out_status_r;
  page_t  out_evicted_r;
  fault_t out_fault_r;
  cnt_t   out_resident_r;

  assign sts.scan_last = (idx_r == idx_t'(FRAMES - 1));

  assign cur_valid = frame_valid_r[idx_r];
  assign cur_page  = frame_page_r[idx_r];
  assign cur_rank  = frame_rank_r[idx_r];

  assign limit = (32'(cfg_r) > FRAMES) ? cnt_t'(FRAMES) : cnt_t'(cfg_r);

  always_comb begin
    status     = ST_ERR;
    slot       = hit_idx_r;
    promo_lim  = '0;
    do_promote = 1'b0;
    do_load    = 1'b0;
    do_fill    = 1'b0;
    evicted    = '0;
    if (limit == '0) begin
      status = ST_ERR;
    end else if (hit_found_r) begin
      status     = ST_HIT;
      slot       = hit_idx_r;
      promo_lim  = cnt_t'(hit_rank_r);
      do_promote = 1'b1;
    end else if (resident_r < limit) begin
      status     = ST_FREE;
      slot       = free_idx_r;
      promo_lim  = cnt_t'(FRAMES);
      do_promote = 1'b1;
      do_load    = 1'b1;
      do_fill    = 1'b1;
    end else begin
      status     = ST_EVICT;
      slot       = vic_idx_r;
      promo_lim  = cnt_t'(vic_rank_r);
      do_promote = 1'b1;
      do_load    = 1'b1;
      evicted    = vic_page_r;
    end
  end

  // Rank update: frames more recent than the touched one age by one.
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      rank_nxt[i] = frame_rank_r[i];
      if (do_promote) begin
        if (idx_t'(i) == slot) begin
          rank_nxt[i] = '0;
        end else if (frame_valid_r[i] && (cnt_t'(frame_rank_r[i]) < promo_lim)) begin
          rank_nxt[i] = frame_rank_r[i] + idx_t'(1);
        end
      end
    end
  end

  assign fault_nxt    = (do_load && (fault_r != '1)) ? fault_r + fault_t'(1) : fault_r;
  assign resident_nxt = do_fill ? resident_r + cnt_t'(1) : resident_r;

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_valid_r <= '0;
      fault_r       <= '0;
      resident_r    <= '0;
      cfg_r         <= cfg_t'(8);
    end else begin
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      if (cmd.commit) begin
        fault_r    <= fault_nxt;
        resident_r <= resident_nxt;
        if (do_fill) frame_valid_r[slot] <= 1'b1;
      end
    end
  end

  // Frame contents and ranks.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < FRAMES; i++) frame_rank_r[i] <= rank_nxt[i];
      if (do_load) frame_page_r[slot] <= page_r;
    end
  end

  // Scan over the frames, one per cycle.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_r       <= in_page_number;
      idx_r        <= '0;
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
      vic_found_r  <= 1'b0;
    end else if (cmd.step) begin
      idx_r <= idx_r + idx_t'(1);
      if (!hit_found_r && cur_valid && (cur_page == page_r)) begin
        hit_found_r <= 1'b1;
        hit_idx_r   <= idx_r;
        hit_rank_r  <= cur_rank;
      end
      if (!free_found_r && !cur_valid) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
      if (cur_valid && (!vic_found_r || (cur_rank > vic_rank_r))) begin
        vic_found_r <= 1'b1;
        vic_idx_r   <= idx_r;
        vic_rank_r  <= cur_rank;
        vic_page_r  <= cur_page;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r   <= status;
      out_evicted_r  <= evicted;
      out_fault_r    <= fault_nxt;
      out_resident_r <= resident_nxt;
    end
  end

  assign out_status         = out_status_r;
  assign out_evicted_page   = out_evicted_r;
  assign out_fault_total    = out_fault_r;
  assign out_resident_count = out_resident_r;

endmodule

`default_nettype wire
